// File: rtl/fqd_pkg.sv
// Types and constants shared by the delete-capable handle queue.
// No dependencies; imported by fqd_seq and fifo_queue_with_delete.
`default_nettype none

package fqd_pkg;

	localparam int HANDLE_FIELD_W = 32;
	localparam int LENGTH_W       = 5;

	typedef logic [1:0] op_t;

	localparam op_t OP_ENQUEUE = 2'd0;
	localparam op_t OP_DEQUEUE = 2'd1;
	localparam op_t OP_DELETE  = 2'd2;

	typedef struct packed {
		op_t                       op;
		logic [HANDLE_FIELD_W-1:0] handle_in;
	} req_t;

	typedef struct packed {
		logic                      status;
		logic [HANDLE_FIELD_W-1:0] handle_out;
		logic [LENGTH_W-1:0]       length;
	} rsp_t;

	// sequencer status toward the top level
	typedef struct packed {
		logic busy;
		logic res_valid;
	} seq_stat_t;

endpackage

`default_nettype wire

// File: rtl/fifo_queue_with_delete.sv
// Bounded FIFO of data handles with enqueue, dequeue and delete by value.
// Depends on fqd_pkg, fqd_seq (which holds the fqd_ram storage).
//
// Request channel (req, req_valid, req_stall): one operation per transfer,
// op is enqueue, dequeue oldest, or delete oldest equal handle. Response
// channel (rsp, rsp_valid, rsp_stall): exactly one result per request with
// status (0 ok, 1 error), the dequeued handle (else zero) and the length.
// Handles are stored at min(HANDLE_WIDTH, 32) bits; zero is not a handle.
// One request is in work at a time; req_stall is high while it is.
// Steps from request transfer to result in the output register:
//   enqueue and requests refused at once (zero handle, full, empty, bad op):
//   straight to the result; dequeue: one RAM read; delete: a read and a
//   compare per entry searched, then a read and a write per entry moved
//   toward the head, set by the single RAM port pair and slot adder.
// A new request is taken the cycle after the result enters the output
// register, so requests never overlap; while the output register holds a
// stalled response, the finished result waits in the sequencer and the
// next request stalls until it moves on.
// Reset empties the queue (head and count to zero); RAM contents are not
// cleared and are never read before written.
`default_nettype none

module fifo_queue_with_delete import fqd_pkg::*; #(
	parameter int DEPTH        = 16,
	parameter int HANDLE_WIDTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire req_t req,
	input  wire logic req_valid,
	output      logic req_stall,
	output      rsp_t rsp,
	output      logic rsp_valid,
	input  wire logic rsp_stall
);

	localparam int DATA_W = (HANDLE_WIDTH < HANDLE_FIELD_W) ? HANDLE_WIDTH : HANDLE_FIELD_W;

	seq_stat_t stat;
	rsp_t      res;
	logic      req_take;
	logic      res_ld;
	logic      out_valid_q;
	rsp_t      rsp_q;

	assign req_stall = stat.busy;
	assign req_take  = req_valid && !stat.busy;
	assign res_ld    = stat.res_valid && (!out_valid_q || !rsp_stall);

	fqd_seq #(
		.DEPTH  (DEPTH),
		.DATA_W (DATA_W)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.req_take (req_take),
		.res_ack  (res_ld),
		.stat     (stat),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ld) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ld) begin
			rsp_q <= res;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = out_valid_q;

	// a finished result only exists while the sequencer holds off requests
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stat.res_valid |-> stat.busy)
		else $error("result pending while sequencer idle");

	// a request transfer always starts work in the sequencer
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |=> stat.busy)
		else $error("request transfer did not start work");

	// error results never carry a handle
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status) |-> (rsp.handle_out == '0))
		else $error("error result with nonzero handle");

	// the output register is never overwritten while a stalled result waits
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled result lost or changed");

endmodule

`default_nettype wire

// File: rtl/fqd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fqd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/fqd_seq.sv
// Handle queue sequencer: one slot adder shared over enqueue, dequeue, search
// and compaction; one comparator for search. Depends on fqd_pkg, fqd_ram.
`default_nettype none

module fqd_seq import fqd_pkg::*; #(
	parameter int DEPTH  = 16,
	parameter int DATA_W = 32
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire req_t      req,
	input  wire logic      req_take,
	input  wire logic      res_ack,
	output      seq_stat_t stat,
	output      rsp_t      res
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int SUMW = CW + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEQ_RD,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_RESP
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     head_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     k_q;
	logic [DATA_W-1:0] h_q;
	logic              status_q;
	logic [DATA_W-1:0] hout_q;

	logic [DATA_W-1:0] h_in;
	logic [CW-1:0]     kp1;
	logic [CW-1:0]     kp2;
	logic [CW-1:0]     off;
	logic [SUMW-1:0]   sum;
	logic [SUMW-1:0]   slot_sum;
	logic [AW-1:0]     slot_idx;
	logic              enq_ok;
	logic              deq_ok;
	logic              del_ok;
	logic              ram_we;
	logic              ram_re;
	logic [DATA_W-1:0] ram_wdata;
	logic [DATA_W-1:0] ram_rdata;
	logic              hit;

	logic [DATA_W+HANDLE_FIELD_W-1:0] hout_ext;
	logic [CW+LENGTH_W-1:0]           len_ext;

	assign h_in = req.handle_in[DATA_W-1:0];
	assign kp1  = k_q + CW'(1);
	assign kp2  = k_q + CW'(2);
	assign hit  = (ram_rdata == h_q);

	assign enq_ok = (req.op == OP_ENQUEUE) && (h_in != '0) && (count_q != CW'(DEPTH));
	assign deq_ok = (req.op == OP_DEQUEUE) && (count_q != '0);
	assign del_ok = (req.op == OP_DELETE) && (h_in != '0) && (count_q != '0);

	// shared slot adder: (head + off) wrapped into the ring
	always_comb begin
		case (state_q)
			S_IDLE:     off = (req.op == OP_ENQUEUE) ? count_q : '0;
			S_DEQ_RD:   off = CW'(1);
			S_SHIFT_RD: off = kp1;
			default:    off = k_q;
		endcase
	end

	assign sum      = {{(SUMW-AW){1'b0}}, head_q} + {1'b0, off};
	assign slot_sum = (sum >= SUMW'(DEPTH)) ? (sum - SUMW'(DEPTH)) : sum;
	assign slot_idx = slot_sum[AW-1:0];

	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_wdata = ram_rdata;
		case (state_q)
			S_IDLE: begin
				ram_we    = req_take && enq_ok;
				ram_re    = req_take && deq_ok;
				ram_wdata = h_in;
			end
			S_SRCH_RD:  ram_re = 1'b1;
			S_SHIFT_RD: ram_re = 1'b1;
			S_SHIFT_WR: ram_we = 1'b1;
			default: begin
				ram_we = 1'b0;
				ram_re = 1'b0;
			end
		endcase
	end

	fqd_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_idx),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (slot_idx),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			count_q  <= '0;
			k_q      <= '0;
			h_q      <= '0;
			status_q <= 1'b1;
			hout_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_take) begin
						h_q      <= h_in;
						k_q      <= '0;
						status_q <= 1'b1;
						hout_q   <= '0;
						state_q  <= S_RESP;
						if (enq_ok) begin
							count_q  <= count_q + CW'(1);
							status_q <= 1'b0;
						end else if (deq_ok) begin
							state_q <= S_DEQ_RD;
						end else if (del_ok) begin
							state_q <= S_SRCH_RD;
						end
					end
				end
				S_DEQ_RD: begin
					hout_q   <= ram_rdata;
					head_q   <= slot_idx;
					count_q  <= count_q - CW'(1);
					status_q <= 1'b0;
					state_q  <= S_RESP;
				end
				S_SRCH_RD: begin
					state_q <= S_SRCH_CMP;
				end
				S_SRCH_CMP: begin
					if (hit) begin
						if (kp1 == count_q) begin
							// match was the last entry: nothing to move
							count_q  <= count_q - CW'(1);
							status_q <= 1'b0;
							state_q  <= S_RESP;
						end else begin
							state_q <= S_SHIFT_RD;
						end
					end else if (kp1 == count_q) begin
						state_q <= S_RESP;
					end else begin
						k_q     <= kp1;
						state_q <= S_SRCH_RD;
					end
				end
				S_SHIFT_RD: begin
					state_q <= S_SHIFT_WR;
				end
				S_SHIFT_WR: begin
					k_q <= kp1;
					if (kp2 == count_q) begin
						count_q  <= count_q - CW'(1);
						status_q <= 1'b0;
						state_q  <= S_RESP;
					end else begin
						state_q <= S_SHIFT_RD;
					end
				end
				S_RESP: begin
					if (res_ack) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign hout_ext = {{HANDLE_FIELD_W{1'b0}}, hout_q};
	assign len_ext  = {{LENGTH_W{1'b0}}, count_q};

	assign res.status     = status_q;
	assign res.handle_out = hout_ext[HANDLE_FIELD_W-1:0];
	assign res.length     = len_ext[LENGTH_W-1:0];

	assign stat.busy      = (state_q != S_IDLE);
	assign stat.res_valid = (state_q == S_RESP);

endmodule

`default_nettype wire
